// ===== rtl/core/ps2mt_pkg.sv =====
// Shared constants for the PS/2 mouse packet cursor tracker.
package ps2mt_pkg;

   // Configuration register widths and indexes.
   localparam int CFG_BITS       = 13;
   localparam int CSR_INDEX_BITS = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = CSR_INDEX_BITS'(1);

   localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = CFG_BITS'(1920);
   localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = CFG_BITS'(1080);

   // Cursor coordinate width and the cursor position after reset.
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int POS_X_RESET        = 400;
   localparam int POS_Y_RESET        = 300;

   // Bit positions within the mouse status byte.
   localparam int STATUS_LEFT_BIT  = 0;
   localparam int STATUS_RIGHT_BIT = 1;
   localparam int STATUS_XSIGN_BIT = 4;
   localparam int STATUS_YSIGN_BIT = 5;

endpackage

// ===== rtl/core/ps2_mouse_packet_cursor_tracker.sv =====
// Top level of the PS/2 mouse packet decoder and cursor tracker.
//
// The request channel (req_valid, req_ready, req_data_byte) takes raw bytes
// from a PS/2 mouse receiver. Bytes are grouped into packets of three: status,
// X movement and Y movement. Every request produces exactly one response on
// the rsp_ channel carrying the current cursor position, the latched button
// state, and rsp_packet_done, which is set when that byte closed a packet.
// On the third byte the movements are sign-extended with status bits 4 and 5,
// X is added to the cursor, Y is subtracted, and each axis is clamped to the
// range from zero to the screen size minus one.
// The response is registered (in the skid register if the output stalls);
// one request per cycle is sustained while responses are taken, set by the
// single add and clamp stage feeding the output register.
// A two-entry output stage (output register plus skid register) lets the
// block take a request while a response is still waiting; req_ready drops
// only when both entries are full because the receiver is stalling.
// Reset clears the packet position and buttons, puts the cursor at
// (400, 300) and loads the screen size registers with 1920 by 1080.
// The csr_ channel is always ready; write it only while the block is idle.
// A register change is seen at the next completed packet.
module ps2_mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ps2mt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ps2mt_pkg::CFG_BITS-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [COORD_BITS-1:0]                 rsp_cursor_x,
   output logic [COORD_BITS-1:0]                 rsp_cursor_y,
   output logic                                  rsp_left_button,
   output logic                                  rsp_right_button,
   output logic                                  rsp_packet_done
);
   import ps2mt_pkg::*;

   // Sum width: an unsigned coordinate plus a 9-bit signed movement.
   localparam int SumW  = COORD_BITS + 2;
   // Width wide enough to compare the screen size against 2^COORD_BITS.
   localparam int WideW = ((COORD_BITS + 1 > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS) + 1;

   localparam logic [COORD_BITS-1:0] PosXInit = COORD_BITS'(POS_X_RESET);
   localparam logic [COORD_BITS-1:0] PosYInit = COORD_BITS'(POS_Y_RESET);

   typedef enum logic [2:0] {
      POS_STATUS = 3'b001,
      POS_XMOVE  = 3'b010,
      POS_YMOVE  = 3'b100
   } byte_pos_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cursor_x;
      logic [COORD_BITS-1:0] cursor_y;
      logic                  left_button;
      logic                  right_button;
      logic                  packet_done;
   } result_type;

   // Largest legal coordinate for a given screen size. A size of zero acts
   // as one, and a size beyond the coordinate range is cut to that range.
   function automatic logic [COORD_BITS-1:0] axis_top(input logic [CFG_BITS-1:0] size);
      logic [WideW-1:0] size_wide;
      begin
         size_wide = WideW'(size);
         if (size == '0) begin
            return '0;
         end else if (size_wide >= (WideW'(1) << COORD_BITS)) begin
            return '1;
         end else begin
            return COORD_BITS'(size_wide - WideW'(1));
         end
      end
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [SumW-1:0] value,
                                                        input logic [COORD_BITS-1:0] top);
      begin
         if (value[SumW-1]) begin
            return '0;
         end else if (value > $signed({2'b00, top})) begin
            return top;
         end else begin
            return value[COORD_BITS-1:0];
         end
      end
   endfunction

   // Configuration registers.
   logic [CFG_BITS-1:0] screen_width_ff, screen_width_in;
   logic [CFG_BITS-1:0] screen_height_ff, screen_height_in;

   // Packet decode state.
   byte_pos_type          byte_pos_ff, byte_pos_in;
   logic [7:0]            status_byte_ff, status_byte_in;
   logic [7:0]            x_move_byte_ff, x_move_byte_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic                  left_pressed_ff, left_pressed_in;
   logic                  right_pressed_ff, right_pressed_in;

   // Output register and skid register.
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   packet_done;
   logic signed [8:0]      dx;
   logic signed [8:0]      dy;
   logic signed [SumW-1:0] sum_x;
   logic signed [SumW-1:0] sum_y;
   result_type             new_result;

   assign csr_ready = 1'b1;
   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~out_valid_ff | rsp_ready;

   // Configuration writes; an index beyond the register list is ignored.
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Movement of the packet in flight: the X byte is held from the previous
   // request, the Y byte is the one arriving now.
   assign dx    = $signed({status_byte_ff[STATUS_XSIGN_BIT], x_move_byte_ff});
   assign dy    = $signed({status_byte_ff[STATUS_YSIGN_BIT], req_data_byte});
   assign sum_x = $signed({2'b00, pos_x_ff}) + SumW'(dx);
   assign sum_y = $signed({2'b00, pos_y_ff}) - SumW'(dy);

   always_comb begin
      byte_pos_in      = byte_pos_ff;
      status_byte_in   = status_byte_ff;
      x_move_byte_in   = x_move_byte_ff;
      pos_x_in         = pos_x_ff;
      pos_y_in         = pos_y_ff;
      left_pressed_in  = left_pressed_ff;
      right_pressed_in = right_pressed_ff;
      packet_done      = 1'b0;
      if (req_fire) begin
         case (byte_pos_ff)
            POS_XMOVE: begin
               x_move_byte_in = req_data_byte;
               byte_pos_in    = POS_YMOVE;
            end
            POS_YMOVE: begin
               pos_x_in         = clamp_axis(sum_x, axis_top(screen_width_ff));
               pos_y_in         = clamp_axis(sum_y, axis_top(screen_height_ff));
               left_pressed_in  = status_byte_ff[STATUS_LEFT_BIT];
               right_pressed_in = status_byte_ff[STATUS_RIGHT_BIT];
               byte_pos_in      = POS_STATUS;
               packet_done      = 1'b1;
            end
            default: begin
               status_byte_in = req_data_byte;
               byte_pos_in    = POS_XMOVE;
            end
         endcase
      end
   end

   assign new_result.cursor_x     = pos_x_in;
   assign new_result.cursor_y     = pos_y_in;
   assign new_result.left_button  = left_pressed_in;
   assign new_result.right_button = right_pressed_in;
   assign new_result.packet_done  = packet_done;

   // The output register reloads whenever it is empty or being taken: first
   // from the skid register, otherwise from a new request. A request that
   // arrives while the output is stalled parks in the skid register.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_result;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         byte_pos_ff      <= POS_STATUS;
         status_byte_ff   <= '0;
         x_move_byte_ff   <= '0;
         pos_x_ff         <= PosXInit;
         pos_y_ff         <= PosYInit;
         left_pressed_ff  <= 1'b0;
         right_pressed_ff <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         byte_pos_ff      <= byte_pos_in;
         status_byte_ff   <= status_byte_in;
         x_move_byte_ff   <= x_move_byte_in;
         pos_x_ff         <= pos_x_in;
         pos_y_ff         <= pos_y_in;
         left_pressed_ff  <= left_pressed_in;
         right_pressed_ff <= right_pressed_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cursor_x     = out_ff.cursor_x;
   assign rsp_cursor_y     = out_ff.cursor_y;
   assign rsp_left_button  = out_ff.left_button;
   assign rsp_right_button = out_ff.right_button;
   assign rsp_packet_done  = out_ff.packet_done;

endmodule

// ===== rtl/core/ps2mt_checker.sv =====
// Port-level assertion checker for the cursor tracker, bound to the top level.
module ps2mt_checker #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_cursor_x,
   input logic [COORD_BITS-1:0] rsp_cursor_y,
   input logic                  rsp_left_button,
   input logic                  rsp_right_button,
   input logic                  rsp_packet_done
);
   logic                  rsp_fire;
   logic [1:0]            gap_ff, gap_in;
   logic                  seen_ff, seen_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in;
   logic [COORD_BITS-1:0] last_y_ff, last_y_in;
   logic                  last_left_ff, last_left_in;
   logic                  last_right_ff, last_right_in;

   assign rsp_fire = rsp_valid & rsp_ready;

   // Track the number of responses since the last completed packet and the
   // last delivered cursor and button state.
   always_comb begin
      gap_in        = gap_ff;
      seen_in       = seen_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      if (rsp_fire) begin
         gap_in        = rsp_packet_done ? 2'd0 : gap_ff + 2'd1;
         seen_in       = 1'b1;
         last_x_in     = rsp_cursor_x;
         last_y_in     = rsp_cursor_y;
         last_left_in  = rsp_left_button;
         last_right_in = rsp_right_button;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff  <= 2'd0;
         seen_ff <= 1'b0;
      end else begin
         gap_ff  <= gap_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      last_x_ff     <= last_x_in;
      last_y_ff     <= last_y_in;
      last_left_ff  <= last_left_in;
      last_right_ff <= last_right_in;
   end

   // No response is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Requests are refused only while a response is waiting.
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("request refused with no response pending");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_x) &&
         $stable(rsp_cursor_y) && $stable(rsp_packet_done))
      else $error("stalled response changed");

   // Every third response closes a packet, starting from reset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_packet_done == (gap_ff == 2'd2)))
      else $error("packet boundary out of step");

   // Cursor and buttons move only on a completed packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_packet_done && seen_ff |->
         rsp_cursor_x == last_x_ff && rsp_cursor_y == last_y_ff &&
         rsp_left_button == last_left_ff && rsp_right_button == last_right_ff)
      else $error("cursor changed without a completed packet");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mt_checker #(.COORD_BITS(COORD_BITS)) u_ps2mt_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the PS/2 mouse packet cursor tracker.
`timescale 1ns / 100ps

module tb;
   import ps2mt_pkg::*;

   localparam int COORD_W = COORD_BITS_DEFAULT;
   localparam int COORD_SPAN = 1 << COORD_W;

   // Register indexes that the block has no register for; writes to them must be dropped.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = CSR_INDEX_BITS'(255);

   // Target for random requests after the directed table.
   localparam int RANDOM_BYTES = 400;

   // One response of the block, field by field.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               left;
      logic               right;
      logic               done;
   } cursor_rsp_type;

   localparam cursor_rsp_type NO_RSP = '0;

   // Where the tracker is within a three-byte packet.
   typedef enum logic [2:0] {
      AWAIT_STATUS = 3'b001,
      AWAIT_X      = 3'b010,
      AWAIT_Y      = 3'b100
   } pkt_phase_type;

   // A directed row either writes a register or sends one mouse byte. A byte row
   // marked with a typed response is checked against that value instead of the
   // predicted one.
   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_BYTE_TYPED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [CFG_BITS-1:0]       csr_val;
      logic [7:0]                data;
      cursor_rsp_type            want;
   } stim_row_type;

   localparam int DIR_ROWS = 34;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [COORD_W-1:0] rsp_cursor_x;
   logic [COORD_W-1:0] rsp_cursor_y;
   logic               rsp_left_button;
   logic               rsp_right_button;
   logic               rsp_packet_done;

   // Shadow copy of the tracker: configuration and packet state, at reset values.
   logic [CFG_BITS-1:0] scr_width = SCREEN_WIDTH_RESET;
   logic [CFG_BITS-1:0] scr_height = SCREEN_HEIGHT_RESET;
   pkt_phase_type       pkt_phase = AWAIT_STATUS;
   logic [7:0]          status_reg = 8'h00;
   logic [7:0]          x_move_reg = 8'h00;
   logic [COORD_W-1:0]  cur_x = COORD_W'(POS_X_RESET);
   logic [COORD_W-1:0]  cur_y = COORD_W'(POS_Y_RESET);
   logic                left_down = 1'b0;
   logic                right_down = 1'b0;

   // Responses still owed by the block, oldest first.
   cursor_rsp_type cursor_q[$];

   int  mismatch_count = 0;
   bit  idle_on = 1'b1;
   int  stall_left = 0;

   stim_row_type dir_tab [0:DIR_ROWS-1];

   ps2_mouse_packet_cursor_tracker u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_right_button (rsp_right_button),
      .rsp_packet_done  (rsp_packet_done)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop well beyond the slowest legal run, even with every gap and stall at its longest.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Idle stretches are mostly short, with an occasional long one.
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // An axis size of zero holds the cursor at 0, and a size beyond the coordinate
   // range is limited to the largest coordinate.
   function automatic logic [COORD_W-1:0] clamp_coord(input int v,
                                                      input logic [CFG_BITS-1:0] size);
      int top;
      if (size == 0) begin
         top = 0;
      end else if (int'(size) > COORD_SPAN) begin
         top = COORD_SPAN - 1;
      end else begin
         top = int'(size) - 1;
      end
      if (v < 0) begin
         return '0;
      end
      if (v > top) begin
         return COORD_W'(top);
      end
      return COORD_W'(v);
   endfunction

   // Advances the shadow tracker by one mouse byte and returns the response it owes.
   // Movement bytes are nine-bit two's complement with the sign held in the status byte.
   // The cursor moves only on the third byte, so a register change shows up there first.
   function automatic cursor_rsp_type advance_tracker(input logic [7:0] b);
      int             dx;
      int             dy;
      cursor_rsp_type r;
      r.done = 1'b0;
      case (pkt_phase)
         AWAIT_X: begin
            x_move_reg = b;
            pkt_phase = AWAIT_Y;
         end
         AWAIT_Y: begin
            dx = int'(x_move_reg) - (status_reg[STATUS_XSIGN_BIT] ? 256 : 0);
            dy = int'(b) - (status_reg[STATUS_YSIGN_BIT] ? 256 : 0);
            cur_x = clamp_coord(int'(cur_x) + dx, scr_width);
            cur_y = clamp_coord(int'(cur_y) - dy, scr_height);
            left_down = status_reg[STATUS_LEFT_BIT];
            right_down = status_reg[STATUS_RIGHT_BIT];
            pkt_phase = AWAIT_STATUS;
            r.done = 1'b1;
         end
         default: begin
            status_reg = b;
            pkt_phase = AWAIT_X;
         end
      endcase
      r.x = cur_x;
      r.y = cur_y;
      r.left = left_down;
      r.right = right_down;
      return r;
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Register write. The caller lowers csr_valid once the last write of a batch is in.
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SCREEN_WIDTH) begin
         scr_width = val;
      end else if (idx == CSR_SCREEN_HEIGHT) begin
         scr_height = val;
      end
   endtask

   // Sends one mouse byte as a request, with an optional random gap in front of it.
   // Valid stays high straight into the next request when there is no gap.
   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input cursor_rsp_type typed_rsp);
      int             gap;
      cursor_rsp_type predicted;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_tracker(b);
      cursor_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // Drops valid and waits until every owed response has come back. Each request
   // yields a response, so an empty queue means the block is idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cursor_q.size() != 0) @(posedge clock);
   endtask

   // Response side: checks each accepted response against the oldest expectation
   // and stalls rsp_ready at random while idling is on.
   always @(posedge clock) begin : rsp_check
      cursor_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cursor_q.size() == 0) begin
               $display("%0t ns: response with no request pending, %s x=%0d y=%0d",
                        $time, "expected none, got", rsp_cursor_x, rsp_cursor_y);
               mismatch_count++;
            end else begin
               want = cursor_q.pop_front();
               check_field("cursor_x", want.x, rsp_cursor_x);
               check_field("cursor_y", want.y, rsp_cursor_y);
               check_field("left_button", want.left, rsp_left_button);
               check_field("right_button", want.right, rsp_right_button);
               check_field("packet_done", want.done, rsp_packet_done);
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) begin
               stall_left = idle_len();
            end
         end
      end
   end

   // Directed part. Typed responses are the ones that are obvious by inspection:
   // the cursor right after reset, an axis held at 0 by a zero size, and clamps at
   // the edges of the screen. The rest come from the predictor.
   initial begin
      dir_tab = '{
         // First packet after reset: the cursor sits at its reset position.
         '{ROW_BYTE_TYPED, CSR_UNUSED_LO, 13'd0, 8'h00, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
         '{ROW_BYTE_TYPED, CSR_UNUSED_LO, 13'd0, 8'h7F, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h80, NO_RSP},
         // Both buttons, both movements negative, including the most negative X.
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h33, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h00, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h01, NO_RSP},
         // Left button only, largest positive Y.
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h11, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h00, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'hFF, NO_RSP},
         // Right button only, X driven below zero.
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h12, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h80, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h00, NO_RSP},
         // Shrink the screen below the cursor: it is not clamped until the next packet.
         '{ROW_CSR,        CSR_SCREEN_WIDTH,  13'd100, 8'h00, NO_RSP},
         '{ROW_CSR,        CSR_SCREEN_HEIGHT, 13'd50,  8'h00, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h20, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h05, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h00, NO_RSP},
         // Zero width holds X at 0; the largest height is limited to the coordinate
         // range; writes to indexes without a register change nothing.
         '{ROW_CSR,        CSR_SCREEN_WIDTH,  13'd0,    8'h00, NO_RSP},
         '{ROW_CSR,        CSR_SCREEN_HEIGHT, 13'd8191, 8'h00, NO_RSP},
         '{ROW_CSR,        CSR_UNUSED_LO,     13'd1,    8'h00, NO_RSP},
         '{ROW_CSR,        CSR_UNUSED_HI,     13'd1,    8'h00, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h00, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h40, NO_RSP},
         '{ROW_BYTE_TYPED, CSR_UNUSED_LO, 13'd0, 8'h00, '{12'd0, 12'd49, 1'b0, 1'b0, 1'b1}},
         // Full-range width, single-row height; the always-one bit of the status byte
         // is not checked. Y goes below zero.
         '{ROW_CSR,        CSR_SCREEN_WIDTH,  13'd4096, 8'h00, NO_RSP},
         '{ROW_CSR,        CSR_SCREEN_HEIGHT, 13'd1,    8'h00, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h08, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'hFF, NO_RSP},
         '{ROW_BYTE_TYPED, CSR_UNUSED_LO, 13'd0, 8'h7F, '{12'd255, 12'd0, 1'b0, 1'b0, 1'b1}},
         // Single-column width, full height; both overflow bits set and ignored.
         '{ROW_CSR,        CSR_SCREEN_WIDTH,  13'd1,    8'h00, NO_RSP},
         '{ROW_CSR,        CSR_SCREEN_HEIGHT, 13'd4096, 8'h00, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'hC0, NO_RSP},
         '{ROW_BYTE,       CSR_UNUSED_LO, 13'd0, 8'h01, NO_RSP},
         '{ROW_BYTE_TYPED, CSR_UNUSED_LO, 13'd0, 8'h80, '{12'd0, 12'd0, 1'b0, 1'b0, 1'b1}}
      };
   end

   // Main stimulus: reset, the directed table, then random phases, each with its own
   // screen size, idling on or off, and a drift direction for the cursor.
   initial begin : stimulus
      int                        sent;
      int                        bias;
      logic [7:0]                st;
      logic [7:0]                xb;
      logic [7:0]                yb;
      bit                        width_first;
      logic [CSR_INDEX_BITS-1:0] size_idx;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(dir_tab[i].csr_idx, dir_tab[i].csr_val);
         end else begin
            send_byte(dir_tab[i].data, dir_tab[i].kind == ROW_BYTE_TYPED, dir_tab[i].want);
         end
      end

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         // New screen size between phases, only once the block has drained. Sizes
         // lean toward the edges: zero, one, the coordinate limit and beyond it.
         wait_idle();
         width_first = 1'($urandom_range(0, 1));
         for (int k = 0; k < 2; k++) begin
            size_idx = ((k == 0) == width_first) ? CSR_SCREEN_WIDTH : CSR_SCREEN_HEIGHT;
            case ($urandom_range(0, 7))
               0:       csr_write(size_idx, 13'd0);
               1:       csr_write(size_idx, 13'd1);
               2:       csr_write(size_idx, CFG_BITS'(COORD_SPAN - 1));
               3:       csr_write(size_idx, CFG_BITS'(COORD_SPAN));
               4:       csr_write(size_idx, 13'd8191);
               7:       csr_write(size_idx, CFG_BITS'($urandom_range(0, 8191)));
               default: csr_write(size_idx, CFG_BITS'($urandom_range(1, COORD_SPAN)));
            endcase
         end
         if ($urandom_range(0, 3) == 0) begin
            csr_write(CSR_INDEX_BITS'($urandom_range(2, 255)), CFG_BITS'($urandom));
         end

         // Some phases run flat out on both sides.
         idle_on = ($urandom_range(0, 3) != 0);
         // Drift: 0 wanders, 1 pushes toward the far corner, 2 toward the origin.
         bias = $urandom_range(0, 2);

         repeat (20) begin
            // A stray byte now and then shifts the packet framing.
            if ($urandom_range(0, 9) == 0) begin
               send_byte(8'($urandom), 1'b0, NO_RSP);
               sent++;
            end
            st = 8'($urandom);
            xb = 8'($urandom);
            yb = 8'($urandom);
            if (bias == 1) begin
               st[STATUS_XSIGN_BIT] = 1'b0;
               st[STATUS_YSIGN_BIT] = 1'b1;
               xb = 8'($urandom_range(192, 255));
               yb = 8'($urandom_range(0, 63));
            end else if (bias == 2) begin
               st[STATUS_XSIGN_BIT] = 1'b1;
               st[STATUS_YSIGN_BIT] = 1'b0;
               xb = 8'($urandom_range(0, 63));
               yb = 8'($urandom_range(192, 255));
            end
            send_byte(st, 1'b0, NO_RSP);
            send_byte(xb, 1'b0, NO_RSP);
            send_byte(yb, 1'b0, NO_RSP);
            sent += 3;
         end
      end

      // Drain, then keep clocking so any stray response gets flagged.
      wait_idle();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
